### design/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  // byte source for the block buffer write port
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } src_e;

  typedef struct packed {
    logic       wr_en;
    src_e       wr_src;
    logic       cnt_inc;
    logic       comp_start;
    logic       hash_init;
    logic       len_clear;
    logic [2:0] rd_word;
  } sha_cmd_t;

  typedef struct packed {
    logic       comp_done;
    logic [5:0] fill;
  } sha_stat_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

### design/sha_datapath.sv
`timescale 1ns / 1ps
module sha_datapath
  import sha_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sha_cmd_t  cmd_i,
  input  logic [7:0] data_i,
  output sha_stat_t stat_o,
  output word_t     hash_word_o
);

  logic [5:0]  fill_q, fill_d;
  logic [63:0] cnt_q, cnt_d;
  word_t       h_q [8];
  word_t       v_q [8];
  word_t       w_q [16];
  logic [6:0]  rnd_q, rnd_d;
  logic        busy_q, busy_d, done_q;
  logic        load_q;
  logic [7:0]  wr_byte;
  logic [63:0] bits;

  assign bits = {cnt_q[60:0], 3'b000};

  always_comb begin
    case (cmd_i.wr_src)
      SRC_DATA: wr_byte = data_i;
      SRC_PAD:  wr_byte = PadByte;
      SRC_ZERO: wr_byte = 8'h00;
      SRC_LEN:  wr_byte = bits[6'd63 - {fill_q[2:0], 3'b000} -: 8];
      default:  wr_byte = 8'h00;
    endcase
  end

  assign fill_d = cmd_i.wr_en ? fill_q + 6'd1 : fill_q;
  assign cnt_d  = cmd_i.len_clear ? 64'd0 : (cmd_i.cnt_inc ? cnt_q + 64'd1 : cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q  <= '0;
    end else begin
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
    end
  end

  // round engine: one round per cycle, 16-word schedule window
  word_t s0, s1, wnew, wcur, t1, t2, e, a;
  assign wcur = w_q[0];
  assign s0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnew = w_q[0] + s0 + w_q[9] + s1;
  assign e    = v_q[4];
  assign a    = v_q[0];
  assign t1   = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & v_q[5]) ^ (~e & v_q[6])) + RoundK[rnd_q[5:0]] + wcur;
  assign t2   = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    busy_d = busy_q;
    rnd_d  = rnd_q;
    if (load_q) begin
      busy_d = 1'b1;
      rnd_d  = '0;
    end else if (busy_q) begin
      rnd_d = rnd_q + 7'd1;
      if (rnd_q == 7'd63) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
      done_q <= 1'b0;
      load_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
    end else begin
      busy_q <= busy_d;
      rnd_q  <= rnd_d;
      load_q <= cmd_i.comp_start;
      done_q <= busy_q && (rnd_q == 7'd63);
      if (cmd_i.hash_init) begin
        for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
      end else if (busy_q && (rnd_q == 7'd63)) begin
        h_q[0] <= h_q[0] + t1 + t2;
        h_q[1] <= h_q[1] + v_q[0];
        h_q[2] <= h_q[2] + v_q[1];
        h_q[3] <= h_q[3] + v_q[2];
        h_q[4] <= h_q[4] + v_q[3] + t1;
        h_q[5] <= h_q[5] + v_q[4];
        h_q[6] <= h_q[6] + v_q[5];
        h_q[7] <= h_q[7] + v_q[6];
      end
    end
  end

  // while idle the window collects the block: bytes shift in at the low end,
  // so after 64 bytes the first one sits at the top of word 0
  always_ff @(posedge clk_i) begin
    if (load_q) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (busy_q) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end else if (cmd_i.wr_en) begin
      for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
      w_q[15] <= {w_q[15][23:0], wr_byte};
    end
  end

  assign stat_o.comp_done = done_q;
  assign stat_o.fill      = fill_q;
  assign hash_word_o      = h_q[cmd_i.rd_word];

endmodule

### design/sha_ctrl.sv
`timescale 1ns / 1ps
module sha_ctrl
  import sha_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      byte_valid_i,
  input  logic      eom_i,
  output logic [7:0] byte_o,
  input  logic [7:0] data_i,
  input  sha_stat_t stat_i,
  output sha_cmd_t  cmd_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic [2:0] word_idx_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_COMP = 8'b0000_0010,
    ST_PAD  = 8'b0000_0100,
    ST_ZERO = 8'b0000_1000,
    ST_LEN  = 8'b0001_0000,
    ST_WAIT = 8'b0010_0000,
    ST_OUT  = 8'b0100_0000,
    ST_FLSH = 8'b1000_0000
  } state_e;

  state_e     state_q, state_d;
  logic       eom_q, eom_d;
  logic       final_q, final_d;
  logic [2:0] idx_q, idx_d;
  logic       acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign word_idx_o  = idx_q;
  assign byte_o      = data_i;

  always_comb begin
    state_d = state_q;
    eom_d   = eom_q;
    final_d = final_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.wr_src  = SRC_DATA;
    cmd_o.rd_word = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          eom_d = eom_i;
          if (byte_valid_i) begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.cnt_inc = 1'b1;
            if (stat_i.fill == 6'd63) begin
              cmd_o.comp_start = 1'b1;
              final_d = 1'b0;
              state_d = ST_COMP;
            end else if (eom_i) begin
              state_d = ST_PAD;
            end
          end else if (eom_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        if (stat_i.comp_done) begin
          state_d = final_q ? ST_OUT : (eom_q ? ST_PAD : ST_IDLE);
          idx_d   = '0;
        end
      end
      ST_PAD: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = SRC_PAD;
        eom_d        = 1'b0;
        if (stat_i.fill == 6'd63) begin
          // pad byte closes the block: zero fill and length go in the next one
          cmd_o.comp_start = 1'b1;
          state_d = ST_FLSH;
        end else begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (stat_i.fill == LenPos) begin
          state_d = ST_LEN;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_src = SRC_ZERO;
          if (stat_i.fill == 6'd63) begin
            cmd_o.comp_start = 1'b1;
            state_d = ST_FLSH;
          end
        end
      end
      ST_FLSH: begin
        if (stat_i.comp_done) begin
          state_d = ST_ZERO;
        end
      end
      ST_LEN: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = SRC_LEN;
        if (stat_i.fill == 6'd63) begin
          cmd_o.comp_start = 1'b1;
          cmd_o.len_clear  = 1'b1;
          final_d = 1'b1;
          state_d = ST_COMP;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.hash_init = 1'b1;
            final_d = 1'b0;
            eom_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      eom_q   <= 1'b0;
      final_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      eom_q   <= eom_d;
      final_q <= final_d;
      idx_q   <= idx_d;
    end
  end

endmodule

### design/sha256_message_digest.sv
`timescale 1ns / 1ps
// SHA-256 over a byte stream, one byte per item.
// Input is taken while idle and stalls while each full 64-byte block is compressed
// (one round per cycle in the shared round unit). End of message: padding writes
// up to 72 bytes, one a cycle while no compression runs and none at the handover
// from zero fill to length; one or two compressions follow, then eight digest items.
// Reset (async, active low) loads the initial hash, clears fill and length.
module sha256_message_digest
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // byte_valid
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, pad
  output logic        m_axis_tlast_o    // last_word
);

  sha_cmd_t   cmd;
  sha_stat_t  stat;
  word_t      hword;
  logic [2:0] widx;
  logic [7:0] byte_w;

  sha_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .byte_valid_i (s_axis_tuser_i),
    .eom_i        (s_axis_tlast_i),
    .byte_o       (byte_w),
    .data_i       (s_axis_tdata_i),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .word_idx_o   (widx)
  );

  sha_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_i      (byte_w),
    .stat_o      (stat),
    .hash_word_o (hword)
  );

  assign m_axis_tdata_o = {5'd0, widx, hword};
  assign m_axis_tlast_o = (widx == 3'd7);

endmodule
